FILE: hw/rtl/spc3_pkg.sv
// ----------------------------------------------------------------------------
// spc3_pkg
// Shared types and codes of the strided, padded 3D correlation engine.
// ----------------------------------------------------------------------------
package spc3_pkg;

	localparam int SumBits    = 48;
	localparam int PosBits    = 18;
	localparam int CfgIdxBits = 3;
	localparam int CfgBits    = 12;
	localparam int OutLimit   = 262144;

	// Operation codes of an input item
	localparam logic [1:0] OP_LOAD_INPUT  = 2'd0;
	localparam logic [1:0] OP_LOAD_KERNEL = 2'd1;
	localparam logic [1:0] OP_EMIT        = 2'd2;

	// Status codes of a result item
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_KERNEL   = 2'd1;
	localparam logic [1:0] ST_SIZE     = 2'd2;

	// Register indexes
	localparam logic [2:0] REG_LX = 3'd0;
	localparam logic [2:0] REG_LY = 3'd1;
	localparam logic [2:0] REG_LZ = 3'd2;
	localparam logic [2:0] REG_WX = 3'd3;
	localparam logic [2:0] REG_WY = 3'd4;
	localparam logic [2:0] REG_WZ = 3'd5;
	localparam logic [2:0] REG_ST = 3'd6;
	localparam logic [2:0] REG_PD = 3'd7;

	typedef struct packed {
		logic [SumBits-1:0] sum;
		logic [PosBits-1:0] position;
		logic               last_output;
		logic [1:0]         status;
	} result_t;

endpackage

FILE: hw/rtl/spc3_if.sv
// ----------------------------------------------------------------------------
// spc3_if
// Valid/ready channel carrying one item of payload type T.
// ----------------------------------------------------------------------------
interface spc3_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/spc3_ram.sv
// ----------------------------------------------------------------------------
// spc3_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module spc3_ram #(
	parameter int Width = 16,
	parameter int Depth = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

FILE: hw/rtl/spc3_mac.sv
// ----------------------------------------------------------------------------
// spc3_mac
// Saturating multiply-accumulate: registered product, then 48-bit add.
// ----------------------------------------------------------------------------
module spc3_mac
	import spc3_pkg::*;
#(
	parameter int SampleBits = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         clear,
	input  logic                         en,
	input  logic signed [SampleBits-1:0] a,
	input  logic signed [SampleBits-1:0] b,
	output logic signed [SumBits-1:0]    acc
);
	localparam int ProdBits = 2 * SampleBits;
	localparam int WideBits = (ProdBits > SumBits ? ProdBits : SumBits) + 2;
	localparam logic signed [WideBits-1:0] MaxW = WideBits'({1'b0, {(SumBits-1){1'b1}}});
	localparam logic signed [WideBits-1:0] MinW = -MaxW - WideBits'(1);

	logic signed [ProdBits-1:0] prod_s1;
	logic                       en_s1;
	logic signed [WideBits-1:0] total;
	logic signed [SumBits-1:0]  acc_q;

	assign total = WideBits'(acc_q) + WideBits'(prod_s1);
	assign acc   = acc_q;

	// register the product, then accumulate with saturation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
			acc_q <= '0;
		end else begin
			en_s1 <= en;
			if (clear) acc_q <= '0;
			else if (en_s1) begin
				if (total > MaxW) acc_q <= MaxW[SumBits-1:0];
				else if (total < MinW) acc_q <= MinW[SumBits-1:0];
				else acc_q <= total[SumBits-1:0];
			end
		end
	end

	always_ff @(posedge clk) prod_s1 <= a * b;
endmodule

FILE: hw/rtl/strided_padded_correlation_3d.sv
// ----------------------------------------------------------------------------
// strided_padded_correlation_3d
// Loads an input volume and a kernel into RAMs and emits one strided,
// zero-padded 3D correlation element per emit item.
//
//   channel | dir | payload
//   in      | in  | opcode[1:0], sample[15:0]
//   out     | out | sum[47:0], position[17:0], last_output, status[1:0]
//   cfg     | in  | cfg_we, cfg_index[2:0], cfg_data[11:0]
//
// A load writes its sample into its RAM as it is accepted. An emit first runs
// a setup sequence: checks, three serial 8-bit dividers and the output count,
// then splits the position by repeated subtraction, planes first, then rows.
// It then walks the kernel one element per cycle along each row through the
// shared MAC, pausing before each row to form its row base. A size or kernel
// error returns from the checks, an output count error after the output count.
// Reset clears the load and output counters and control; the RAMs are not
// cleared. Input stalls while an item is in work or a result waits; the result
// register holds until taken.
// ----------------------------------------------------------------------------
module strided_padded_correlation_3d
	import spc3_pkg::*;
#(
	parameter int INPUT_DEPTH  = 4096,
	parameter int KERNEL_DEPTH = 512,
	parameter int SAMPLE_BITS  = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	spc3_if.sink                    in,
	spc3_if.source                  out,
	input  logic                    cfg_we,
	input  logic [CfgIdxBits-1:0]   cfg_index,
	input  logic [CfgBits-1:0]      cfg_data
);
	localparam int IAW = $clog2(INPUT_DEPTH);
	localparam int KAW = $clog2(KERNEL_DEPTH);
	localparam int ICW = IAW + 1;
	localparam int KCW = KAW + 1;
	localparam int VW  = 21;   // volume of three 7-bit extents
	localparam int DW  = 8;    // padded extent up to 127 + 30

	// states
	localparam logic [3:0] S_IDLE = 4'd0, S_CHK = 4'd1, S_DIV = 4'd2, S_TOT = 4'd3,
		S_TOT2 = 4'd4, S_SPLIT = 4'd5, S_RUN = 4'd6, S_DRAIN = 4'd7,
		S_DONE = 4'd8, S_TOT3 = 4'd9, S_SPL2 = 4'd10;

	// configuration registers
	logic [6:0]  lx_q, ly_q, lz_q;
	logic [4:0]  wx_q, wy_q, wz_q;
	logic [11:0] st_q, pd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lx_q <= 7'd1; ly_q <= 7'd1; lz_q <= 7'd1;
			wx_q <= 5'd1; wy_q <= 5'd1; wz_q <= 5'd1;
			st_q <= 12'd273; pd_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LX: lx_q <= cfg_data[6:0];
				REG_LY: ly_q <= cfg_data[6:0];
				REG_LZ: lz_q <= cfg_data[6:0];
				REG_WX: wx_q <= cfg_data[4:0];
				REG_WY: wy_q <= cfg_data[4:0];
				REG_WZ: wz_q <= cfg_data[4:0];
				REG_ST: st_q <= cfg_data;
				REG_PD: pd_q <= cfg_data;
			endcase
		end
	end

	// volumes of the configured extents
	logic [VW-1:0] ivol, kvol;
	logic [13:0]   ixy;
	logic [9:0]    kxy;
	assign ixy  = 14'(lx_q) * 14'(ly_q);
	assign kxy  = 10'(wx_q) * 10'(wy_q);
	assign ivol = VW'(ixy) * VW'(lz_q);
	assign kvol = VW'(kxy) * VW'(wz_q);

	// strides and paddings
	logic [3:0] sx, sy, sz, px, py, pz;
	assign sx = (st_q[3:0]  == 4'd0) ? 4'd1 : st_q[3:0];
	assign sy = (st_q[7:4]  == 4'd0) ? 4'd1 : st_q[7:4];
	assign sz = (st_q[11:8] == 4'd0) ? 4'd1 : st_q[11:8];
	assign px = pd_q[3:0];
	assign py = pd_q[7:4];
	assign pz = pd_q[11:8];
	logic [DW-1:0] tx, ty, tz;
	assign tx = DW'(lx_q) + DW'({px, 1'b0});
	assign ty = DW'(ly_q) + DW'({py, 1'b0});
	assign tz = DW'(lz_q) + DW'({pz, 1'b0});

	// load counters and RAM writes
	logic [ICW-1:0] icnt_q;
	logic [KCW-1:0] kcnt_q;
	logic [3:0]     state_q;
	logic           acc_in;
	logic [1:0]     op;
	result_t        res_q;
	logic           res_v_q;

	assign op     = in.data.opcode;
	assign in.ready = (state_q == S_IDLE) && !res_v_q;
	assign acc_in = in.valid && in.ready;

	logic [VW:0] ilim, klim;
	assign ilim = (ivol < VW'(INPUT_DEPTH))  ? {1'b0, ivol} : (VW+1)'(INPUT_DEPTH);
	assign klim = (kvol < VW'(KERNEL_DEPTH)) ? {1'b0, kvol} : (VW+1)'(KERNEL_DEPTH);

	logic iwe, kwe;
	assign iwe = acc_in && op == OP_LOAD_INPUT && icnt_q < ICW'(INPUT_DEPTH);
	assign kwe = acc_in && op == OP_LOAD_KERNEL && kcnt_q < KCW'(KERNEL_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			icnt_q <= '0; kcnt_q <= '0;
		end else if (acc_in) begin
			if (op == OP_LOAD_INPUT)
				icnt_q <= ((VW+1)'(icnt_q) + 1'b1 >= ilim || ilim == '0) ? '0 : icnt_q + 1'b1;
			if (op == OP_LOAD_KERNEL)
				kcnt_q <= ((VW+1)'(kcnt_q) + 1'b1 >= klim || klim == '0) ? '0 : kcnt_q + 1'b1;
		end
	end

	// read addresses, read data and the two RAMs
	logic [IAW-1:0] iraddr;
	logic [KAW-1:0] kraddr;
	logic [SAMPLE_BITS-1:0] irdata, krdata;

	spc3_ram #(.Width(SAMPLE_BITS), .Depth(INPUT_DEPTH)) u_iram (
		.clk, .we(iwe), .waddr(icnt_q[IAW-1:0]), .wdata(SAMPLE_BITS'(in.data.sample)),
		.raddr(iraddr), .rdata(irdata));
	spc3_ram #(.Width(SAMPLE_BITS), .Depth(KERNEL_DEPTH)) u_kram (
		.clk, .we(kwe), .waddr(kcnt_q[KAW-1:0]), .wdata(SAMPLE_BITS'(in.data.sample)),
		.raddr(kraddr), .rdata(krdata));

	// serial dividers: (t - w) / s, one quotient bit per cycle, all three axes
	logic [DW-1:0] rx_q, ry_q, rz_q, qx_q, qy_q, qz_q;
	logic [3:0]    bit_q;
	logic [DW-1:0] ox, oy, oz;
	assign ox = qx_q + 1'b1;
	assign oy = qy_q + 1'b1;
	assign oz = qz_q + 1'b1;

	function automatic logic [2*DW-1:0] div_step(logic [DW-1:0] r, logic [DW-1:0] q,
		logic [3:0] s, logic [3:0] b);
		logic [DW+3:0] t;
		begin
			t = (DW+4)'(s) << b;
			if ((DW+4)'(r) >= t) return {DW'((DW+4)'(r) - t), q | (DW'(1) << b)};
			return {r, q};
		end
	endfunction

	// output sizes, position and its split
	logic [15:0]        oxy_q;
	logic [VW+8:0]      total_q;
	logic [PosBits-1:0] ocnt_q, p_q, rem_q;
	logic [DW-1:0]      n1_q, n2_q, n3_q;
	logic [PosBits-1:0] sub_q;

	// kernel walk counters and base coordinates
	logic [4:0]  kx_q, ky_q, kz_q;
	logic [8:0]  bx_q, by_q, bz_q;
	logic [KAW-1:0] ka_q;
	logic        rd_s1;
	logic        mac_clr;
	logic signed [SumBits-1:0] acc;

	spc3_mac #(.SampleBits(SAMPLE_BITS)) u_mac (
		.clk, .arst_n, .clear(mac_clr), .en(rd_s1),
		.a(irdata), .b(krdata), .acc(acc));

	// current coordinates and validity of this kernel tap
	logic [9:0] x, y, z;
	logic       tap_ok;
	logic [6:0] xi, yi, zi;
	assign x = 10'(bx_q) + 10'(kx_q);
	assign y = 10'(by_q) + 10'(ky_q);
	assign z = 10'(bz_q) + 10'(kz_q);
	assign xi = 7'(x - 10'(px));
	assign yi = 7'(y - 10'(py));
	assign zi = 7'(z - 10'(pz));
	assign tap_ok = x >= 10'(px) && (x - 10'(px)) < 10'(lx_q)
		&& y >= 10'(py) && (y - 10'(py)) < 10'(ly_q)
		&& z >= 10'(pz) && (z - 10'(pz)) < 10'(lz_q);

	// input address: xi + lx*(yi + ly*zi), built from registered row base
	logic [19:0] plane_q, row_q;
	assign iraddr = IAW'(20'(xi) + row_q);
	assign kraddr = ka_q;

	logic klast_x, klast_y, klast_z;
	assign klast_x = kx_q == wx_q - 1'b1;
	assign klast_y = ky_q == wy_q - 1'b1;
	assign klast_z = kz_q == wz_q - 1'b1;
	logic [1:0] dr_q;

	assign mac_clr = (state_q == S_SPL2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ocnt_q  <= '0;
			res_v_q <= 1'b0;
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= (state_q == S_RUN) && tap_ok;
			if (out.valid && out.ready) res_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (acc_in && op == OP_EMIT) state_q <= S_CHK;
				S_CHK: begin
					if (ivol == '0 || kvol == '0 || ivol > VW'(INPUT_DEPTH)
						|| kvol > VW'(KERNEL_DEPTH)) begin
						res_q   <= '{sum: '0, position: '0, last_output: 1'b0, status: ST_SIZE};
						res_v_q <= 1'b1; state_q <= S_IDLE;
					end else if (DW'(wx_q) > tx || DW'(wy_q) > ty || DW'(wz_q) > tz) begin
						res_q   <= '{sum: '0, position: '0, last_output: 1'b0, status: ST_KERNEL};
						res_v_q <= 1'b1; state_q <= S_IDLE;
					end else begin
						rx_q <= tx - DW'(wx_q); ry_q <= ty - DW'(wy_q); rz_q <= tz - DW'(wz_q);
						qx_q <= '0; qy_q <= '0; qz_q <= '0;
						bit_q <= 4'(DW - 1);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					{rx_q, qx_q} <= div_step(rx_q, qx_q, sx, bit_q);
					{ry_q, qy_q} <= div_step(ry_q, qy_q, sy, bit_q);
					{rz_q, qz_q} <= div_step(rz_q, qz_q, sz, bit_q);
					if (bit_q == '0) state_q <= S_TOT;
					else bit_q <= bit_q - 1'b1;
				end
				S_TOT: begin
					oxy_q <= ox * oy;
					state_q <= S_TOT2;
				end
				S_TOT2: begin
					total_q <= (VW+9)'(oxy_q * oz);
					state_q <= S_TOT3;
				end
				S_TOT3: begin
					if (total_q > (VW+9)'(OutLimit)) begin
						res_q   <= '{sum: '0, position: '0, last_output: 1'b0, status: ST_SIZE};
						res_v_q <= 1'b1; state_q <= S_IDLE;
					end else begin
						p_q   <= ((VW+9)'(ocnt_q) < total_q) ? ocnt_q : '0;
						rem_q <= ((VW+9)'(ocnt_q) < total_q) ? ocnt_q : '0;
						n1_q <= '0; n2_q <= '0; n3_q <= '0;
						sub_q <= PosBits'(oxy_q);
						dr_q <= 2'd0;
						state_q <= S_SPLIT;
					end
				end
				S_SPLIT: begin
					// split by repeated subtraction: planes, then rows (up to 156 each)
					if (dr_q == 2'd0) begin
						if (rem_q >= sub_q) begin
							rem_q <= rem_q - sub_q; n3_q <= n3_q + 1'b1;
						end else begin
							sub_q <= PosBits'(ox);
							dr_q <= 2'd1;
						end
					end else if (rem_q >= sub_q) begin
						rem_q <= rem_q - sub_q; n2_q <= n2_q + 1'b1;
					end else begin
						n1_q <= DW'(rem_q);
						state_q <= S_SPL2;
					end
				end
				S_SPL2: begin
					bx_q <= 9'(n1_q * sx);
					by_q <= 9'(n2_q * sy);
					bz_q <= 9'(n3_q * sz);
					kx_q <= '0; ky_q <= '0; kz_q <= '0; ka_q <= '0;
					dr_q <= 2'd0;
					state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					// prepare row base for the current (ky,kz) before walking x
					plane_q <= 20'(zi) * 20'(ly_q);
					dr_q <= dr_q + 1'b1;
					if (dr_q == 2'd1) begin
						row_q <= 20'(ixy) == '0 ? '0 : (plane_q + 20'(yi)) * 20'(lx_q);
					end
					if (dr_q == 2'd2) state_q <= S_RUN;
				end
				S_RUN: begin
					ka_q  <= ka_q + 1'b1;
					if (!klast_x) kx_q <= kx_q + 1'b1;
					else begin
						kx_q <= '0;
						dr_q <= 2'd0;
						if (!klast_y) begin
							ky_q <= ky_q + 1'b1; state_q <= S_DRAIN;
						end else if (!klast_z) begin
							ky_q <= '0; kz_q <= kz_q + 1'b1; state_q <= S_DRAIN;
						end else state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// wait for the last products to land in the accumulator
					dr_q <= dr_q + 1'b1;
					if (dr_q == 2'd3) begin
						res_q <= '{sum: acc, position: p_q,
							last_output: (VW+9)'(p_q) + 1'b1 == total_q, status: ST_OK};
						res_v_q <= 1'b1;
						ocnt_q <= ((VW+9)'(p_q) + 1'b1 == total_q) ? '0 : p_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out.valid = res_v_q;
	assign out.data  = res_q;
endmodule
